### design/lccc_pkg.sv
// ----------------------------------------------------------------------------
// lccc_pkg
// Types, constants and helper functions shared by the LED color cross-fade
// sequencer and its per-tick step logic.
// ----------------------------------------------------------------------------
package lccc_pkg;

    localparam int PALETTE_SLOTS = 6;

    // Configuration register indexes.
    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_COUNT  = 3'd1;
    localparam logic [2:0] REG_COLOR0 = 3'd2;
    localparam logic [2:0] REG_COLOR5 = 3'd7;

    // Color channel codes.
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    localparam logic [2:0] LAST_PHASE  = 3'd5;
    localparam logic [2:0] LAST_SEGMENT = 3'(PALETTE_SLOTS - 1);
    localparam logic [7:0] CHANNEL_MAX = 8'hFF;
    localparam logic [7:0] RAINBOW_STEP = 8'd3;

    typedef logic [23:0] color_t;  // red in [23:16], green in [15:8], blue in [7:0]

    typedef struct packed {
        logic       primed;
        logic [2:0] phase;
        logic [2:0] segment;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } lccc_state_t;

    // Channel that moves in each rainbow phase: G up, R down, B up, G down, R up, B down.
    function automatic logic [1:0] phase_channel(input logic [2:0] p);
        logic [1:0] ch;
        case (p)
            3'd0, 3'd3: ch = CH_GREEN;
            3'd1, 3'd4: ch = CH_RED;
            default:    ch = CH_BLUE;
        endcase
        return ch;
    endfunction

    // Saturating move by three toward full scale or toward zero.
    function automatic logic [7:0] rainbow_move(input logic [7:0] v, input logic rising);
        logic [7:0] r;
        if (rising)
            r = (v >= CHANNEL_MAX - RAINBOW_STEP) ? CHANNEL_MAX : v + RAINBOW_STEP;
        else
            r = (v <= RAINBOW_STEP) ? 8'd0 : v - RAINBOW_STEP;
        return r;
    endfunction

    function automatic logic [7:0] toward(input logic [7:0] cur, input logic [7:0] tgt);
        logic [7:0] r;
        if (cur < tgt)
            r = cur + 8'd1;
        else if (cur > tgt)
            r = cur - 8'd1;
        else
            r = cur;
        return r;
    endfunction

endpackage

### design/led_color_crossfade_cycle.sv
// ----------------------------------------------------------------------------
// led_color_crossfade_cycle
// Frame-tick color sequencer for an LED strip: rainbow cycle or palette fade.
// ----------------------------------------------------------------------------
// Each word on the s_axis side is one frame tick; s_tdata[0] restarts the
// sequence from its start color before the tick. Each tick gives at most one
// word on the m_axis side carrying the frame color. A palette tick whose
// current color already equals the target advances the segment and gives
// no word. An accepted tick passes from the input register through the step
// logic into the output register, which drives m_tvalid. One tick is accepted
// per cycle for as long as the output register drains; the state update is a
// single pass of 8-bit step and compare logic. When the receiver stalls, the
// color word holds in the output register and one more tick waits in the
// input register before s_tready drops. The cfg port writes registers 0..7
// (mode, count, six palette colors); the user must do so only while the block
// is idle, as the block does not enforce it. A change of mode makes the next
// tick load the new mode's start color. After reset the block is in rainbow
// mode with palette count 2, all palette colors black, and the first tick
// starts at red.
// ----------------------------------------------------------------------------
module led_color_crossfade_cycle
    import lccc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [0] restart_sequence, [7:1] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] frame_red, [15:8] frame_green, [23:16] frame_blue
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    logic                       in_valid_reg;
    logic                       restart_reg;
    logic                       out_valid_reg;
    logic [23:0]                out_data_reg;
    lccc_state_t                state_reg;
    lccc_state_t                state_next;
    logic                       mode_reg;
    logic [2:0]                 count_reg;
    color_t [PALETTE_SLOTS-1:0] palette_reg;
    logic                       emit;
    color_t                     frame_color;
    logic                       out_free;
    logic                       advance;
    logic                       mode_change;

    lccc_step u_step (
        .state_in      (state_reg),
        .restart       (restart_reg),
        .palette_mode  (mode_reg),
        .palette_count (count_reg),
        .palette       (palette_reg),
        .state_next    (state_next),
        .emit          (emit),
        .frame_color   (frame_color)
    );

    assign out_free    = !out_valid_reg || m_tready;
    assign advance     = in_valid_reg && (!emit || out_free);
    assign s_tready    = !in_valid_reg || advance;
    assign mode_change = cfg_we && (cfg_index == REG_MODE) && (cfg_data[0] != mode_reg);
    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance && emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (mode_change)
                state_reg.primed <= 1'b0;
            else if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            restart_reg <= s_tdata[0];
        if (advance && emit)
            out_data_reg <= {frame_color[7:0], frame_color[15:8], frame_color[23:16]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b0;
            count_reg   <= 3'd2;
            palette_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index) inside
                REG_MODE:                 mode_reg  <= cfg_data[0];
                REG_COUNT:                count_reg <= cfg_data[2:0];
                [REG_COLOR0:REG_COLOR5]:  palette_reg[cfg_index - REG_COLOR0] <= cfg_data;
                default:                  ;
            endcase
        end
    end

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase <= LAST_PHASE)
        else $error("rainbow phase out of range");

    a_segment_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.segment <= LAST_SEGMENT)
        else $error("palette segment out of range");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit) |=> m_tvalid)
        else $error("emitted color did not reach the output register");

    a_primed_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !cfg_we) |=> state_reg.primed)
        else $error("state not primed after a processed tick");

endmodule

### design/lccc_step.sv
// ----------------------------------------------------------------------------
// lccc_step
// Next-state and frame color logic for one tick, in rainbow or palette mode.
// ----------------------------------------------------------------------------
module lccc_step
    import lccc_pkg::*;
(
    input  lccc_state_t                     state_in,
    input  logic                            restart,
    input  logic                            palette_mode,
    input  logic [2:0]                      palette_count,
    input  color_t [PALETTE_SLOTS-1:0]      palette,
    output lccc_state_t                     state_next,
    output logic                            emit,
    output color_t                          frame_color
);

    lccc_state_t cur;
    logic [2:0]  p;
    logic [2:0]  used;
    logic [3:0]  seg_inc;
    logic [2:0]  tgt_idx;
    color_t      tgt;
    logic [1:0]  ch;
    logic        rising;
    logic [7:0]  ch_val;
    logic [7:0]  moved;
    logic [7:0]  goal;

    always_comb
    begin
        cur = state_in;
        if (!state_in.primed || restart)
        begin
            cur.primed = 1'b1;
            if (palette_mode)
            begin
                cur.red     = palette[0][23:16];
                cur.green   = palette[0][15:8];
                cur.blue    = palette[0][7:0];
                cur.segment = 3'd0;
            end
            else
            begin
                cur.red   = CHANNEL_MAX;
                cur.green = 8'd0;
                cur.blue  = 8'd0;
                cur.phase = 3'd0;
            end
        end
    end

    // Rainbow path.
    always_comb
    begin
        p      = (cur.phase > LAST_PHASE) ? 3'd0 : cur.phase;
        ch     = phase_channel(p);
        rising = ~p[0];
        case (ch)
            CH_RED:   ch_val = cur.red;
            CH_GREEN: ch_val = cur.green;
            default:  ch_val = cur.blue;
        endcase
        moved = rainbow_move(ch_val, rising);
        goal  = rising ? CHANNEL_MAX : 8'd0;
    end

    // Palette path: a count of zero acts as one and seven acts as six.
    always_comb
    begin
        if (palette_count == 3'd0)
            used = 3'd1;
        else if (palette_count > 3'(PALETTE_SLOTS))
            used = 3'(PALETTE_SLOTS);
        else
            used = palette_count;
        seg_inc = {1'b0, cur.segment} + 4'd1;
        tgt_idx = (seg_inc >= {1'b0, used}) ? 3'd0 : seg_inc[2:0];
        tgt     = palette[tgt_idx];
    end

    always_comb
    begin
        state_next  = cur;
        frame_color = {cur.red, cur.green, cur.blue};
        emit        = 1'b1;
        if (!palette_mode)
        begin
            case (ch)
                CH_RED:   state_next.red   = moved;
                CH_GREEN: state_next.green = moved;
                default:  state_next.blue  = moved;
            endcase
            if (moved == goal)
                state_next.phase = (p == LAST_PHASE) ? 3'd0 : p + 3'd1;
            else
                state_next.phase = p;
        end
        else if ({cur.red, cur.green, cur.blue} == tgt)
        begin
            // Segment turns over; this tick gives no word.
            state_next.segment = tgt_idx;
            emit               = 1'b0;
        end
        else
        begin
            state_next.red   = toward(cur.red,   tgt[23:16]);
            state_next.green = toward(cur.green, tgt[15:8]);
            state_next.blue  = toward(cur.blue,  tgt[7:0]);
        end
    end

endmodule
